### hw/rtl/cmpq_pkg.sv
package cmpq_pkg;

   localparam int POS_W  = 32;
   localparam int VEL_W  = 32;
   localparam int DUR_W  = 16;
   localparam int TPS_W  = 10;
   localparam int STOP_W = 16;
   localparam int WORD_W = 32;
   localparam int CSR_W  = 16;

   // Signed width of the acceleration and jerk numerators and their magnitude.
   localparam int NUM_W = 54;
   localparam int MAG_W = NUM_W - 1;

   localparam logic [TPS_W-1:0]  TPS_RESET  = 10'd250;
   localparam logic [STOP_W-1:0] STOP_RESET = 16'd25;

   typedef enum logic [1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_POLL    = 2'd1,
      MODE_RESET   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_FULL          = 2'd1,
      STATUS_ZERO_DURATION = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_INIT  = 3'd1,
      CMD_MOVE  = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_RESET = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      PHASE_OFF      = 2'd0,
      PHASE_IDLE     = 2'd1,
      PHASE_ACTIVE   = 2'd2,
      PHASE_STOPPING = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_QUIET = 2'd0,
      KIND_MOVE  = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_TICKS_PER_SECOND = 1'b0,
      CSR_STOP_TICKS       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        capture;
      logic        wr_en;
      logic        rd_en;
      logic        load_seg;
      logic        div_start;
      logic        div_sel;
      logic        take_a;
      logic        take_j;
      logic        clr_cur;
      logic        stop_vel;
      logic        upd_cur;
      logic        emit;
      kind_type    kind;
      status_type  status;
      command_type command;
      phase_type   phase;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_busy;
   } dp_status_type;

endpackage

### hw/rtl/cubic_move_planner_queue_top.sv
// An enqueue, a poll that plans nothing, and a reset pass through the capture, decide and
// emit states before the result item is loaded; a move also loads its segment, steps through
// the product pipeline and runs the bit-serial divider once for accel and once for jerk.
// One item at a time; the next item is accepted once the previous result is
// loaded into the output register. Reset is synchronous and active high; it empties the
// queue, enters the off phase and restores ticks_per_second 250 and stop_ticks 25.
module cubic_move_planner_queue_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int FRACTION_BITS = 40,
   parameter int STEP_CLOCK_HZ = 100000000
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write channel. Index 0 is ticks_per_second, index 1 is stop_ticks.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [cmpq_pkg::CSR_W-1:0]          csr_data,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic signed [cmpq_pkg::POS_W-1:0]   req_target_position,
   input  logic signed [cmpq_pkg::VEL_W-1:0]   req_target_velocity,
   input  logic [cmpq_pkg::DUR_W-1:0]          req_duration_ticks,
   input  logic                                req_unit_busy,
   input  logic                                req_unit_done,
   // Response channel, one item per request item.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [2:0]                          rsp_command,
   output logic [cmpq_pkg::DUR_W-1:0]          rsp_steps,
   output logic signed [cmpq_pkg::WORD_W-1:0]  rsp_accel,
   output logic signed [cmpq_pkg::WORD_W-1:0]  rsp_jerk,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    rsp_queue_count,
   output logic [1:0]                          rsp_phase
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // The controller owns the phase, the queue head and the fill count. The datapath
   // owns the segment memory, the current position and velocity, the product
   // pipeline, the shared divider and the output register.
   cmpq_pkg::ctrl_cmd_type  cmd;
   cmpq_pkg::dp_status_type sts;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [CW-1:0]           queue_count;

   // Registers always writable; user must write only while block is idle, not enforced.
   assign csr_ready = 1'b1;

   cmpq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_duration_ticks (req_duration_ticks),
      .req_unit_busy      (req_unit_busy),
      .req_unit_done      (req_unit_done),
      .sts                (sts),
      .cmd                (cmd),
      .wr_addr            (wr_addr),
      .rd_addr            (rd_addr),
      .queue_count        (queue_count)
   );

   cmpq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS),
      .STEP_CLOCK_HZ (STEP_CLOCK_HZ)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_target_position (req_target_position),
      .req_target_velocity (req_target_velocity),
      .req_duration_ticks  (req_duration_ticks),
      .cmd                 (cmd),
      .sts                 (sts),
      .wr_addr             (wr_addr),
      .rd_addr             (rd_addr),
      .queue_count         (queue_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_command         (rsp_command),
      .rsp_steps           (rsp_steps),
      .rsp_accel           (rsp_accel),
      .rsp_jerk            (rsp_jerk),
      .rsp_queue_count     (rsp_queue_count),
      .rsp_phase           (rsp_phase)
   );

endmodule

### hw/rtl/cmpq_ram.sv
module cmpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cmpq_div.sv
// Restoring divider: one quotient bit per cycle, trunc(|num| * 2^FB / den),
// then saturated and signed to a 32-bit word.
module cmpq_div #(
   parameter int FRACTION_BITS = 40,
   parameter int DEN_W         = 78
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [cmpq_pkg::NUM_W-1:0]      num,
   input  logic [DEN_W-1:0]                       den,
   output logic                                   busy,
   output logic signed [cmpq_pkg::WORD_W-1:0]     result
);

   localparam int DVD_W = cmpq_pkg::MAG_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam int QW    = cmpq_pkg::WORD_W;

   logic [DVD_W-1:0]  dvd_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [QW-1:0]     q_ff;
   logic              ovf_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [cmpq_pkg::NUM_W-1:0] mag;
   logic [DEN_W:0]             rem_sh;
   logic                       ge;
   logic [DEN_W:0]             rem_in;
   logic                       sat;
   logic [QW-1:0]              q_neg;

   assign mag    = num[cmpq_pkg::NUM_W-1] ? (cmpq_pkg::NUM_W'(0) - num) : num;
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (start) begin
         neg_ff <= num[cmpq_pkg::NUM_W-1];
         dvd_ff <= {mag[cmpq_pkg::MAG_W-1:0], {FRACTION_BITS{1'b0}}};
         rem_ff <= '0;
         den_ff <= den;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in[DEN_W-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[QW-1];
      end
   end

   // A negative result may reach -2^31; a positive one stops at 2^31 - 1.
   assign sat   = ovf_ff | (neg_ff ? (q_ff > {1'b1, {(QW-1){1'b0}}}) : q_ff[QW-1]);
   assign q_neg = QW'(0) - q_ff;

   always_comb begin
      if (sat) begin
         result = neg_ff ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
         result = neg_ff ? q_neg : q_ff;
      end
   end

   assign busy = cnt_ff != '0;

endmodule

### hw/rtl/cmpq_ctrl.sv
module cmpq_ctrl #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [cmpq_pkg::DUR_W-1:0]           req_duration_ticks,
   input  logic                                 req_unit_busy,
   input  logic                                 req_unit_done,
   input  cmpq_pkg::dp_status_type              sts,
   output cmpq_pkg::ctrl_cmd_type               cmd,
   output logic [$clog2(QUEUE_DEPTH)-1:0]       wr_addr,
   output logic [$clog2(QUEUE_DEPTH)-1:0]       rd_addr,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_count
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_LOAD, ST_M1, ST_M2, ST_M3, ST_M4,
      ST_DIVA, ST_WAITA, ST_DIVJ, ST_WAITJ, ST_EMIT
   } state_type;

   state_type               state_ff;
   cmpq_pkg::mode_type      mode_ff;
   logic                    dur_zero_ff;
   logic                    busy_ff;
   logic                    done_ff;
   cmpq_pkg::phase_type     phase_ff;
   logic [CW-1:0]           count_ff;
   logic [AW-1:0]           head_ff;
   cmpq_pkg::status_type    status_ff;
   cmpq_pkg::command_type   command_ff;
   cmpq_pkg::kind_type      kind_ff;

   cmpq_pkg::phase_type     phase_in;
   logic [CW-1:0]           count_in;
   logic [AW-1:0]           head_in;
   cmpq_pkg::status_type    status_in;
   cmpq_pkg::command_type   command_in;
   cmpq_pkg::kind_type      kind_in;
   logic                    plan;
   logic                    wr;
   logic                    clr;
   logic                    stopv;
   logic [CW:0]             tail_sum;
   logic [AW-1:0]           head_inc;

   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign wr_addr  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign head_inc = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign rd_addr  = head_ff;

   // Decision for the captured item.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      status_in  = cmpq_pkg::STATUS_OK;
      command_in = cmpq_pkg::CMD_NONE;
      kind_in    = cmpq_pkg::KIND_QUIET;
      plan       = 1'b0;
      wr         = 1'b0;
      clr        = 1'b0;
      stopv      = 1'b0;
      unique case (mode_ff)
         cmpq_pkg::MODE_ENQUEUE: begin
            if (count_ff >= CW'(QUEUE_DEPTH)) begin
               status_in = cmpq_pkg::STATUS_FULL;
            end else if (dur_zero_ff) begin
               status_in = cmpq_pkg::STATUS_ZERO_DURATION;
            end else begin
               wr       = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         cmpq_pkg::MODE_POLL: begin
            unique case (phase_ff)
               cmpq_pkg::PHASE_OFF: begin
                  if (count_ff != '0) begin
                     command_in = cmpq_pkg::CMD_INIT;
                     clr        = 1'b1;
                     phase_in   = cmpq_pkg::PHASE_IDLE;
                  end
               end
               cmpq_pkg::PHASE_IDLE: begin
                  if (count_ff != '0) begin
                     plan     = 1'b1;
                     phase_in = cmpq_pkg::PHASE_ACTIVE;
                  end
               end
               cmpq_pkg::PHASE_ACTIVE: begin
                  if (!busy_ff) begin
                     if (count_ff != '0) begin
                        plan = 1'b1;
                     end else if (done_ff) begin
                        command_in = cmpq_pkg::CMD_STOP;
                        kind_in    = cmpq_pkg::KIND_STOP;
                        stopv      = 1'b1;
                        phase_in   = cmpq_pkg::PHASE_STOPPING;
                     end
                  end
               end
               default: begin
                  if (!busy_ff && done_ff) begin
                     phase_in = cmpq_pkg::PHASE_IDLE;
                  end
               end
            endcase
         end
         cmpq_pkg::MODE_RESET: begin
            count_in   = '0;
            head_in    = '0;
            phase_in   = cmpq_pkg::PHASE_OFF;
            clr        = 1'b1;
            command_in = cmpq_pkg::CMD_RESET;
         end
         default: begin
         end
      endcase
      if (plan) begin
         command_in = cmpq_pkg::CMD_MOVE;
         kind_in    = cmpq_pkg::KIND_MOVE;
         count_in   = count_ff - 1'b1;
         head_in    = head_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= cmpq_pkg::PHASE_OFF;
         count_ff   <= '0;
         head_ff    <= '0;
         mode_ff    <= cmpq_pkg::MODE_UNUSED;
         status_ff  <= cmpq_pkg::STATUS_OK;
         command_ff <= cmpq_pkg::CMD_NONE;
         kind_ff    <= cmpq_pkg::KIND_QUIET;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff     <= cmpq_pkg::mode_type'(req_mode);
                  dur_zero_ff <= req_duration_ticks == '0;
                  busy_ff     <= req_unit_busy;
                  done_ff     <= req_unit_done;
                  state_ff    <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               phase_ff   <= phase_in;
               count_ff   <= count_in;
               head_ff    <= head_in;
               status_ff  <= status_in;
               command_ff <= command_in;
               kind_ff    <= kind_in;
               state_ff   <= plan ? ST_LOAD : ST_EMIT;
            end
            ST_LOAD:  state_ff <= ST_M1;
            ST_M1:    state_ff <= ST_M2;
            ST_M2:    state_ff <= ST_M3;
            ST_M3:    state_ff <= ST_M4;
            ST_M4:    state_ff <= ST_DIVA;
            ST_DIVA:  state_ff <= ST_WAITA;
            ST_WAITA: begin
               if (!sts.div_busy) begin
                  state_ff <= ST_DIVJ;
               end
            end
            ST_DIVJ:  state_ff <= ST_WAITJ;
            ST_WAITJ: begin
               if (!sts.div_busy) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!sts.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign queue_count = count_ff;

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.wr_en     = (state_ff == ST_DECIDE) && wr;
      cmd.rd_en     = (state_ff == ST_DECIDE) && plan;
      cmd.clr_cur   = (state_ff == ST_DECIDE) && clr;
      cmd.stop_vel  = (state_ff == ST_DECIDE) && stopv;
      cmd.load_seg  = state_ff == ST_LOAD;
      cmd.div_start = (state_ff == ST_DIVA) || (state_ff == ST_DIVJ);
      cmd.div_sel   = state_ff == ST_DIVJ;
      cmd.take_a    = (state_ff == ST_WAITA) && !sts.div_busy;
      cmd.take_j    = (state_ff == ST_WAITJ) && !sts.div_busy;
      cmd.emit      = (state_ff == ST_EMIT) && !sts.out_busy;
      cmd.upd_cur   = cmd.emit && (kind_ff == cmpq_pkg::KIND_MOVE);
      cmd.kind      = kind_ff;
      cmd.status    = status_ff;
      cmd.command   = command_ff;
      cmd.phase     = phase_ff;
   end

endmodule

### hw/rtl/cmpq_datapath.sv
module cmpq_datapath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int FRACTION_BITS = 40,
   parameter int STEP_CLOCK_HZ = 100000000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [0:0]                          csr_index,
   input  logic [cmpq_pkg::CSR_W-1:0]          csr_data,
   input  logic signed [cmpq_pkg::POS_W-1:0]   req_target_position,
   input  logic signed [cmpq_pkg::VEL_W-1:0]   req_target_velocity,
   input  logic [cmpq_pkg::DUR_W-1:0]          req_duration_ticks,
   input  cmpq_pkg::ctrl_cmd_type              cmd,
   output cmpq_pkg::dp_status_type             sts,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [2:0]                          rsp_command,
   output logic [cmpq_pkg::DUR_W-1:0]          rsp_steps,
   output logic signed [cmpq_pkg::WORD_W-1:0]  rsp_accel,
   output logic signed [cmpq_pkg::WORD_W-1:0]  rsp_jerk,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    rsp_queue_count,
   output logic [1:0]                          rsp_phase
);

   localparam int DW     = cmpq_pkg::DUR_W;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int SEG_W  = cmpq_pkg::POS_W + cmpq_pkg::VEL_W + DW;
   localparam int HZ_W   = $clog2(STEP_CLOCK_HZ + 1);
   localparam int DENA_W = HZ_W + 2 * DW;
   localparam int DEN_W  = HZ_W + 3 * DW;
   localparam int DX_W   = cmpq_pkg::POS_W + 1;
   localparam int DXF_W  = DX_W + cmpq_pkg::TPS_W + 1;
   localparam int SA_W   = cmpq_pkg::VEL_W + 2;
   localparam int PA_W   = SA_W + DW + 1;
   localparam int SV_W   = cmpq_pkg::VEL_W + 1;
   localparam int PV_W   = SV_W + DW + 1;
   localparam int NW     = cmpq_pkg::NUM_W;
   localparam logic [HZ_W-1:0] HZ = HZ_W'(STEP_CLOCK_HZ);

   logic [cmpq_pkg::TPS_W-1:0]         tps_ff;
   logic [cmpq_pkg::STOP_W-1:0]        stop_ff;
   logic signed [cmpq_pkg::POS_W-1:0]  in_pos_ff;
   logic signed [cmpq_pkg::VEL_W-1:0]  in_vel_ff;
   logic [DW-1:0]                      in_dur_ff;
   logic signed [cmpq_pkg::POS_W-1:0]  cur_pos_ff;
   logic signed [cmpq_pkg::VEL_W-1:0]  cur_vel_ff;
   logic signed [cmpq_pkg::POS_W-1:0]  seg_pos_ff;
   logic signed [cmpq_pkg::VEL_W-1:0]  seg_vel_ff;
   logic [DW-1:0]                      seg_dur_ff;
   logic [SEG_W-1:0]                   ram_rd;

   logic signed [DXF_W-1:0]  dxf_ff;
   logic signed [PA_W-1:0]   pa_ff;
   logic signed [PV_W-1:0]   pv_ff;
   logic [2*DW-1:0]          n2_ff;
   logic signed [NW-1:0]     anum_ff;
   logic signed [NW-1:0]     jnum_ff;
   logic [3*DW-1:0]          n3_ff;
   logic [DENA_W-1:0]        dena_ff;
   logic [HZ_W+2*DW-1:0]     denj_lo_ff;
   logic [HZ_W+DW-1:0]       denj_hi_ff;
   logic [DEN_W-1:0]         denj_ff;
   logic signed [cmpq_pkg::WORD_W-1:0] accel_ff;
   logic signed [cmpq_pkg::WORD_W-1:0] jerk_ff;

   logic signed [DX_W-1:0]   dx;
   logic signed [SA_W-1:0]   sa;
   logic signed [SV_W-1:0]   sv;
   logic signed [DW:0]       n_s;
   logic signed [DXF_W:0]    tps_s;
   logic signed [NW-1:0]     dxf_w;
   logic signed [NW-1:0]     jd;
   logic                     div_busy;
   logic signed [cmpq_pkg::WORD_W-1:0] div_result;

   logic                              rsp_valid_ff;
   logic [1:0]                        rsp_status_ff;
   logic [2:0]                        rsp_command_ff;
   logic [DW-1:0]                     rsp_steps_ff;
   logic signed [cmpq_pkg::WORD_W-1:0] rsp_accel_ff;
   logic signed [cmpq_pkg::WORD_W-1:0] rsp_jerk_ff;
   logic [CW-1:0]                     rsp_count_ff;
   logic [1:0]                        rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff  <= cmpq_pkg::TPS_RESET;
         stop_ff <= cmpq_pkg::STOP_RESET;
      end else if (csr_valid) begin
         case (cmpq_pkg::csr_index_type'(csr_index))
            cmpq_pkg::CSR_TICKS_PER_SECOND: tps_ff <= csr_data[cmpq_pkg::TPS_W-1:0];
            default:                        stop_ff <= csr_data[cmpq_pkg::STOP_W-1:0];
         endcase
      end
   end

   cmpq_ram #(.WIDTH(SEG_W), .DEPTH(QUEUE_DEPTH)) u_seg_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({in_pos_ff, in_vel_ff, in_dur_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_pos_ff <= req_target_position;
         in_vel_ff <= req_target_velocity;
         in_dur_ff <= req_duration_ticks;
      end
      if (cmd.load_seg) begin
         {seg_pos_ff, seg_vel_ff, seg_dur_ff} <= ram_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_cur) begin
         cur_pos_ff <= '0;
         cur_vel_ff <= '0;
      end else if (cmd.stop_vel) begin
         cur_vel_ff <= '0;
      end else if (cmd.upd_cur) begin
         cur_pos_ff <= seg_pos_ff;
         cur_vel_ff <= seg_vel_ff;
      end
   end

   assign dx    = DX_W'(seg_pos_ff) - DX_W'(cur_pos_ff);
   assign sa    = (SA_W'(cur_vel_ff) <<< 1) + SA_W'(seg_vel_ff);
   assign sv    = SV_W'(cur_vel_ff) + SV_W'(seg_vel_ff);
   assign n_s   = $signed({1'b0, seg_dur_ff});
   assign tps_s = $signed({{(DXF_W + 1 - cmpq_pkg::TPS_W){1'b0}}, tps_ff});
   assign dxf_w = NW'(dxf_ff);
   assign jd    = NW'(pv_ff) - (dxf_w <<< 1);

   // Product pipeline; it settles while the controller steps through its wait states.
   always_ff @(posedge clock) begin
      dxf_ff     <= DXF_W'(DXF_W'(dx) * DXF_W'(tps_s));
      pa_ff      <= PA_W'(sa) * PA_W'(n_s);
      pv_ff      <= PV_W'(sv) * PV_W'(n_s);
      n2_ff      <= (2*DW)'(seg_dur_ff) * (2*DW)'(seg_dur_ff);
      anum_ff    <= (dxf_w <<< 2) + (dxf_w <<< 1) - (NW'(pa_ff) <<< 1);
      jnum_ff    <= (jd <<< 2) + (jd <<< 1);
      n3_ff      <= (3*DW)'(n2_ff) * (3*DW)'(seg_dur_ff);
      dena_ff    <= DENA_W'(HZ) * DENA_W'(n2_ff);
      denj_lo_ff <= (HZ_W+2*DW)'(HZ) * (HZ_W+2*DW)'(n3_ff[2*DW-1:0]);
      denj_hi_ff <= (HZ_W+DW)'(HZ) * (HZ_W+DW)'(n3_ff[3*DW-1:2*DW]);
      denj_ff    <= DEN_W'(denj_lo_ff) + (DEN_W'(denj_hi_ff) << (2*DW));
   end

   cmpq_div #(.FRACTION_BITS(FRACTION_BITS), .DEN_W(DEN_W)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num    (cmd.div_sel ? jnum_ff : anum_ff),
      .den    (cmd.div_sel ? denj_ff : DEN_W'(dena_ff)),
      .busy   (div_busy),
      .result (div_result)
   );

   always_ff @(posedge clock) begin
      if (cmd.take_a) begin
         accel_ff <= div_result;
      end
      if (cmd.take_j) begin
         jerk_ff <= div_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_status_ff  <= cmd.status;
         rsp_command_ff <= cmd.command;
         rsp_count_ff   <= queue_count;
         rsp_phase_ff   <= cmd.phase;
         case (cmd.kind)
            cmpq_pkg::KIND_MOVE: begin
               rsp_steps_ff <= seg_dur_ff;
               rsp_accel_ff <= accel_ff;
               rsp_jerk_ff  <= jerk_ff;
            end
            cmpq_pkg::KIND_STOP: begin
               rsp_steps_ff <= stop_ff;
               rsp_accel_ff <= '0;
               rsp_jerk_ff  <= '0;
            end
            default: begin
               rsp_steps_ff <= '0;
               rsp_accel_ff <= '0;
               rsp_jerk_ff  <= '0;
            end
         endcase
      end
   end

   assign sts.div_busy = div_busy;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_steps       = rsp_steps_ff;
   assign rsp_accel       = rsp_accel_ff;
   assign rsp_jerk        = rsp_jerk_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_phase       = rsp_phase_ff;

endmodule

### hw/rtl/cmpq_checker.sv
module cmpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_command,
   input logic [15:0] rsp_steps,
   input logic [31:0] rsp_accel,
   input logic [31:0] rsp_jerk
);

   // A response held under backpressure stays valid and keeps its accel and jerk words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accel) && $stable(rsp_jerk))
      else $error("response changed while stalled");

   // Only queued segments are planned, and those never have zero duration.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == cmpq_pkg::CMD_MOVE) |-> rsp_steps != '0)
      else $error("move issued with zero steps");

   // Items that issue neither a move nor a stop carry no motion words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command != cmpq_pkg::CMD_MOVE) && (rsp_command != cmpq_pkg::CMD_STOP)
      |-> (rsp_steps == '0) && (rsp_accel == '0) && (rsp_jerk == '0))
      else $error("quiet item carries motion data");

   // A rejected enqueue issues no command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cmpq_pkg::STATUS_OK) |-> rsp_command == cmpq_pkg::CMD_NONE)
      else $error("rejected item issued a command");

   // Reset drops any pending response.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cubic_move_planner_queue_top cmpq_checker u_cmpq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_command (rsp_command),
   .rsp_steps   (rsp_steps),
   .rsp_accel   (rsp_accel),
   .rsp_jerk    (rsp_jerk)
);
